// ===== rtl/core/ufrc_pkg.sv =====
// shared types and constants of the frame receive checker
`default_nettype none

package ufrc_pkg;

    // fixed field widths and frame byte counts
    localparam int BYTE_W         = 8;
    localparam int STATUS_W       = 3;
    localparam int LEN_W          = 6;
    localparam int CFG_ADDR_W     = 3;
    localparam int FRAME_OVERHEAD = 8;
    localparam int HDR_BYTES      = 6;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_FIRST  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_SECOND = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_EXP_CLASS   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_EXP_ID      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_EXP_LENGTH  = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_SYNC  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_CLASS = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_ID    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_BAD_LEN   = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_BAD_CKSUM = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic take;        // store the accepted word
        logic start;       // word opens a new frame
        logic rd_ck_a;     // read first checksum byte
        logic rd_ck_b;     // read second checksum byte
        logic cap_ck_a;    // capture first checksum byte
        logic rd_replay;   // read the next replay byte
        logic ld_fail;     // load a failure result
        logic ld_replay;   // load a replay result
        logic replay_clr;  // rewind the replay index
    } ufrc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic                is_sync;
        logic                frame_end;
        logic                out_free;
        logic [STATUS_W-1:0] check_code;
        logic                replay_last;
    } ufrc_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/ufrc_ctrl.sv =====
// frame receive checker controller state machine
`default_nettype none

module ufrc_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire ufrc_pkg::ufrc_stat_t  stat,
    output ufrc_pkg::ufrc_cmd_t        cmd
);

    localparam logic [2:0] ST_HUNT    = 3'd0;
    localparam logic [2:0] ST_COLLECT = 3'd1;
    localparam logic [2:0] ST_CK_A    = 3'd2;
    localparam logic [2:0] ST_CK_B    = 3'd3;
    localparam logic [2:0] ST_EVAL    = 3'd4;
    localparam logic [2:0] ST_RD      = 3'd5;
    localparam logic [2:0] ST_LD      = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       fire;

    assign s_tready = (state_reg == ST_HUNT) || (state_reg == ST_COLLECT);
    assign fire     = s_tvalid && s_tready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_HUNT: begin
                if (fire && stat.is_sync) begin
                    cmd.take  = 1'b1;
                    cmd.start = 1'b1;
                    state_next = stat.frame_end ? ST_CK_A : ST_COLLECT;
                end
            end
            ST_COLLECT: begin
                if (fire) begin
                    cmd.take = 1'b1;
                    if (stat.frame_end) begin
                        state_next = ST_CK_A;
                    end
                end
            end
            ST_CK_A: begin
                cmd.rd_ck_a = 1'b1;
                state_next  = ST_CK_B;
            end
            ST_CK_B: begin
                cmd.rd_ck_b  = 1'b1;
                cmd.cap_ck_a = 1'b1;
                state_next   = ST_EVAL;
            end
            ST_EVAL: begin
                if (stat.out_free) begin
                    if (stat.check_code != ufrc_pkg::STAT_OK) begin
                        cmd.ld_fail = 1'b1;
                        state_next  = ST_HUNT;
                    end else begin
                        cmd.replay_clr = 1'b1;
                        state_next     = ST_RD;
                    end
                end
            end
            ST_RD: begin
                if (stat.out_free) begin
                    cmd.rd_replay = 1'b1;
                    state_next    = ST_LD;
                end
            end
            ST_LD: begin
                cmd.ld_replay = 1'b1;
                state_next    = stat.replay_last ? ST_HUNT : ST_RD;
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ufrc_datapath.sv =====
// frame receive checker datapath: config, frame store, sums, checks, output register
`default_nettype none

module ufrc_datapath #(
    parameter int MAX_PAYLOAD = 56
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [ufrc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [ufrc_pkg::BYTE_W-1:0]          cfg_wr_data,
    input  wire logic [ufrc_pkg::BYTE_W-1:0]          s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [ufrc_pkg::BYTE_W-1:0]               m_tdata,
    output logic [ufrc_pkg::STATUS_W-1:0]             m_tuser,
    output logic                                      m_tlast,
    input  wire ufrc_pkg::ufrc_cmd_t                  cmd,
    output ufrc_pkg::ufrc_stat_t                      stat
);

    localparam int ADDR_W = $clog2(MAX_PAYLOAD + ufrc_pkg::FRAME_OVERHEAD);
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int CNT_W  = ADDR_W + 1;
    localparam int LEN_W  = ufrc_pkg::LEN_W;
    localparam int BW     = ufrc_pkg::BYTE_W;
    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_PAYLOAD);
    localparam logic [CNT_W-1:0] OVERHEAD = CNT_W'(ufrc_pkg::FRAME_OVERHEAD);

    // configuration registers
    logic [BW-1:0]    sync_first_reg;
    logic [BW-1:0]    sync_second_reg;
    logic [BW-1:0]    exp_class_reg;
    logic [BW-1:0]    exp_id_reg;
    logic [LEN_W-1:0] exp_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= 8'd181;
            sync_second_reg <= 8'd98;
            exp_class_reg   <= 8'd1;
            exp_id_reg      <= 8'd2;
            exp_len_reg     <= 6'd28;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ufrc_pkg::REG_SYNC_FIRST:  sync_first_reg  <= cfg_wr_data;
                ufrc_pkg::REG_SYNC_SECOND: sync_second_reg <= cfg_wr_data;
                ufrc_pkg::REG_EXP_CLASS:   exp_class_reg   <= cfg_wr_data;
                ufrc_pkg::REG_EXP_ID:      exp_id_reg      <= cfg_wr_data;
                ufrc_pkg::REG_EXP_LENGTH:  exp_len_reg     <= cfg_wr_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // frame size from the registers in force for this word
    logic [LEN_W-1:0] len_cur;
    logic [CNT_W-1:0] frame_len_cur;

    assign len_cur       = (exp_len_reg > MAX_LEN) ? MAX_LEN : exp_len_reg;
    assign frame_len_cur = CNT_W'(len_cur) + OVERHEAD;

    // collect side
    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] pos;
    logic [CNT_W-1:0]  pos_ext;
    logic [CNT_W-1:0]  pos_inc;
    logic              in_sum;
    logic [BW-1:0]     sum_a_reg;
    logic [BW-1:0]     sum_b_reg;
    logic [BW-1:0]     base_a;
    logic [BW-1:0]     base_b;
    logic [BW-1:0]     sum_a_next;
    logic [BW-1:0]     sum_b_next;
    logic [BW-1:0]     hdr_reg [ufrc_pkg::HDR_BYTES];
    logic [LEN_W-1:0]  len_reg;
    logic [CNT_W-1:0]  frame_len_reg;

    // count is zero whenever a frame opens, so no select on start here
    assign pos        = count_reg[ADDR_W-1:0];
    assign pos_ext    = {1'b0, pos};
    assign pos_inc    = pos_ext + CNT_W'(1);
    assign in_sum     = (pos_ext >= CNT_W'(2)) && ((pos_ext + CNT_W'(2)) < frame_len_cur);
    assign base_a     = cmd.start ? '0 : sum_a_reg;
    assign base_b     = cmd.start ? '0 : sum_b_reg;
    assign sum_a_next = base_a + s_tdata;
    assign sum_b_next = base_b + sum_a_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
        end else if (cmd.take) begin
            count_reg <= stat.frame_end ? '0 : pos_inc;
            sum_a_reg <= in_sum ? sum_a_next : base_a;
            sum_b_reg <= in_sum ? sum_b_next : base_b;
        end
    end

    // header bytes kept beside the store for the checks
    always_ff @(posedge aclk) begin
        if (cmd.take && (pos_ext < CNT_W'(ufrc_pkg::HDR_BYTES))) begin
            hdr_reg[pos[2:0]] <= s_tdata;
        end
        if (cmd.take && stat.frame_end) begin
            len_reg <= len_cur;
        end
    end

    assign frame_len_reg = CNT_W'(len_reg) + OVERHEAD;

    // frame store
    logic [BW-1:0]     mem [DEPTH];
    logic [BW-1:0]     rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic [CNT_W-1:0]  idx_reg;
    logic [BW-1:0]     ck_a_reg;

    assign rd_en = cmd.rd_ck_a || cmd.rd_ck_b || cmd.rd_replay;

    always_comb begin
        if (cmd.rd_ck_a) begin
            rd_addr = ADDR_W'(len_reg) + ADDR_W'(6);
        end else if (cmd.rd_ck_b) begin
            rd_addr = ADDR_W'(len_reg) + ADDR_W'(7);
        end else begin
            rd_addr = idx_reg[ADDR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            mem[pos] <= s_tdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_ck_a) begin
            ck_a_reg <= rd_data_reg;
        end
        if (cmd.replay_clr) begin
            idx_reg <= '0;
        end else if (cmd.ld_replay) begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    // frame checks in priority order, second checksum byte straight from the read port
    logic [ufrc_pkg::STATUS_W-1:0] check_code;

    always_comb begin
        if ((hdr_reg[0] != sync_first_reg) || (hdr_reg[1] != sync_second_reg)) begin
            check_code = ufrc_pkg::STAT_BAD_SYNC;
        end else if (hdr_reg[2] != exp_class_reg) begin
            check_code = ufrc_pkg::STAT_BAD_CLASS;
        end else if (hdr_reg[3] != exp_id_reg) begin
            check_code = ufrc_pkg::STAT_BAD_ID;
        end else if ((hdr_reg[5] != '0) || (hdr_reg[4] != BW'(len_reg))) begin
            check_code = ufrc_pkg::STAT_BAD_LEN;
        end else if ((ck_a_reg != sum_a_reg) || (rd_data_reg != sum_b_reg)) begin
            check_code = ufrc_pkg::STAT_BAD_CKSUM;
        end else begin
            check_code = ufrc_pkg::STAT_OK;
        end
    end

    // output register
    logic                          out_valid_reg;
    logic [BW-1:0]                 out_byte_reg;
    logic [ufrc_pkg::STATUS_W-1:0] out_status_reg;
    logic                          out_last_reg;
    logic                          replay_last;

    assign replay_last = (idx_reg + CNT_W'(1)) == frame_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.ld_fail || cmd.ld_replay) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_fail) begin
            out_byte_reg   <= '0;
            out_status_reg <= check_code;
            out_last_reg   <= 1'b1;
        end else if (cmd.ld_replay) begin
            out_byte_reg   <= rd_data_reg;
            out_status_reg <= ufrc_pkg::STAT_OK;
            out_last_reg   <= replay_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    assign stat.is_sync     = (s_tdata == sync_first_reg);
    assign stat.frame_end   = pos_inc >= frame_len_cur;
    assign stat.out_free    = !out_valid_reg || m_tready;
    assign stat.check_code  = check_code;
    assign stat.replay_last = replay_last;

endmodule

`default_nettype wire

// ===== rtl/core/ubx_frame_receive_checker.sv =====
// top level of the framed serial receive checker with fletcher checksum
// collect: one word per cycle while hunting or collecting a frame
// check: two store reads fetch the checksum bytes after the last frame word, then a compare
// replay: each of the len+8 frame words is read from the store, then loaded once the output is free
// a failure gives one word; the input stalls from the last frame word until the last result loads
// aresetn is synchronous, active low: config back to defaults, hunting, sums and count zero
`default_nettype none

module ubx_frame_receive_checker #(
    parameter int MAX_PAYLOAD = 56   // payload cap, sets the frame store depth
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration writes
    input  wire logic                              cfg_wr_en,
    input  wire logic [ufrc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [ufrc_pkg::BYTE_W-1:0]       cfg_wr_data,
    // received serial words
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ufrc_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] rx_byte
    // result words
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [ufrc_pkg::BYTE_W-1:0]            m_tdata,   // [7:0] frame_byte
    output logic [ufrc_pkg::STATUS_W-1:0]          m_tuser,   // [2:0] status
    output logic                                   m_tlast    // last word of the frame result
);

    // command and status between controller and datapath
    ufrc_pkg::ufrc_cmd_t  cmd;
    ufrc_pkg::ufrc_stat_t stat;

    // sequencing: hunt, collect, checksum reads, evaluate, replay
    ufrc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // config registers, frame store, running sums, checks and output register
    ufrc_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire

// ===== rtl/core/ufrc_checker.sv =====
// port level checks of the frame receive checker and their bind
`default_nettype none

module ufrc_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              cfg_wr_en,
    input wire logic [ufrc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input wire logic [ufrc_pkg::BYTE_W-1:0]       cfg_wr_data,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic [ufrc_pkg::BYTE_W-1:0]       s_tdata,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [ufrc_pkg::BYTE_W-1:0]       m_tdata,
    input wire logic [ufrc_pkg::STATUS_W-1:0]     m_tuser,
    input wire logic                              m_tlast
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result word changed");

    // a failure word is a single last word with zero data
    a_fail_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ufrc_pkg::STAT_OK) |-> m_tlast && (m_tdata == '0))
        else $error("failure word malformed");

    // status code stays within the defined codes
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= ufrc_pkg::STAT_BAD_CKSUM))
        else $error("undefined status code");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind ubx_frame_receive_checker ufrc_checker u_ufrc_checker (.*);

`default_nettype wire
